// ===== rtl/core/fbfl_pkg.sv =====
// Shared constants for the fixed-size block free-list allocator.
// Field widths, command codes and register indexes. No dependencies.
`default_nettype none

package fbfl_pkg;

  // byte offsets handed out and accepted by the allocator
  localparam int OFFSET_WIDTH = 20;

  localparam int BUF_SIZE_W  = 21;
  localparam int BLK_SIZE_W  = 16;
  localparam int RBS_W       = 17;  // block size after rounding to a multiple of four
  localparam int REQ_W       = 16;
  localparam int SHIFT_W     = 4;
  localparam int CMD_W       = 2;
  localparam int CFG_INDEX_W = 1;

  // restoring divider: one quotient bit per cycle over the buffer-size width
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(BUF_SIZE_W - 1);

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/fixed_block_free_list_allocator_top.sv =====
// Fixed-size block allocator: sequencer, shared divider and free-list state.
// Depends on fbfl_pkg and fbfl_ram (link table).
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, always ready): index 0 writes buffer_size,
//   index 1 writes block_size. Write only while the block is idle.
//   in channel: command 0 init, 1 allocate, 2 free; one result beat per command
//   on the out channel (status, block_offset, available_blocks).
//   in_ready is high only while no command is in flight; one command at a time.
// States from accept to result (the result then waits for a free output register):
//   reject at the first check (zero size, too large, empty, range, cmd 3): result directly
//   allocate: link read, head update, result
//   free past the range check: the 21-step restoring divider, divider end, result
//   init: divider, divider end, then the resulting blocks chained one link per cycle, result
// The next command can be accepted the cycle after a result enters the output
// register; a new command is not taken until the last result has left the sequencer.
// If the receiver stalls with a result already waiting, the following result
// is held internally and in_ready stays low until it moves out.
// Reset clears the list (empty, zero blocks), both size registers and the
// channels; the link table itself is not cleared and is rebuilt by init.
`default_nettype none

module fixed_block_free_list_allocator_top #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,

  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [fbfl_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire logic [fbfl_pkg::BUF_SIZE_W-1:0]          cfg_data,

  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic [fbfl_pkg::CMD_W-1:0]               command,
  input  wire logic [fbfl_pkg::REQ_W-1:0]               request_size,
  input  wire logic [fbfl_pkg::SHIFT_W-1:0]             align_shift,
  input  wire logic [fbfl_pkg::OFFSET_WIDTH-1:0]        free_offset,

  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic                                          status,
  output logic      [fbfl_pkg::OFFSET_WIDTH-1:0]        block_offset,
  output logic      [$clog2(MAX_BLOCKS+1)-1:0]          available_blocks
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int LINK_W = $clog2(MAX_BLOCKS + 1);   // also the count width
  localparam int BUF_W  = fbfl_pkg::BUF_SIZE_W;
  localparam int RBS_W  = fbfl_pkg::RBS_W;
  localparam int OFF_W  = fbfl_pkg::OFFSET_WIDTH;

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_BLOCKS);
  localparam logic [BUF_W-1:0]  MAXB_Q   = BUF_W'(MAX_BLOCKS);
  localparam logic [BUF_W-1:0]  BUF_CAP  = BUF_W'(1) << OFF_W;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_DIV       = 7'b0000010,
    ST_DIV_END   = 7'b0000100,
    ST_FILL      = 7'b0001000,
    ST_ALLOC_RD  = 7'b0010000,
    ST_ALLOC_UPD = 7'b0100000,
    ST_RESP      = 7'b1000000
  } state_t;

  state_t state;

  // configuration and list state
  logic [BUF_W-1:0]                  buffer_size;
  logic [fbfl_pkg::BLK_SIZE_W-1:0]   block_size;
  logic [RBS_W-1:0]                  rbs;
  logic [IDX_W-1:0]                  list_head;
  logic                              list_nonempty;
  logic [LINK_W-1:0]                 free_count;

  // command context
  logic [fbfl_pkg::CMD_W-1:0]        cmd;
  logic [fbfl_pkg::DIV_CNT_W-1:0]    div_cnt;
  logic [RBS_W-1:0]                  div_rem;
  logic [BUF_W-1:0]                  div_q;
  logic [LINK_W-1:0]                 fill_idx;
  logic [LINK_W-1:0]                 fill_cnt;

  // pending result
  logic                              res_status;
  logic [OFF_W-1:0]                  res_offset;
  logic [LINK_W-1:0]                 res_avail;

  // combinational helpers
  logic [RBS_W-1:0]                  rbs_new;
  logic [BUF_W-1:0]                  bytes_capped;
  logic [RBS_W-1:0]                  align_mask;
  logic [RBS_W-1:0]                  aligned;
  logic [RBS_W:0]                    div_shift;
  logic                              div_ge;
  logic [RBS_W-1:0]                  div_rem_next;
  logic [LINK_W-1:0]                 div_count;
  logic                              free_ok;
  logic [IDX_W+RBS_W-1:0]            head_prod;
  logic [LINK_W-1:0]                 fill_next;
  logic [LINK_W-1:0]                 link_rd;
  logic                              link_wr_en;
  logic [IDX_W-1:0]                  link_wr_addr;
  logic [LINK_W-1:0]                 link_wr_data;
  logic                              link_rd_en;
  logic                              res_move;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign rbs_new      = (RBS_W'(block_size) + RBS_W'(3)) & ~RBS_W'(3);
  assign bytes_capped = (buffer_size > BUF_CAP) ? BUF_CAP : buffer_size;
  assign align_mask   = (RBS_W'(1) << align_shift) - RBS_W'(1);
  assign aligned      = (RBS_W'(request_size) + align_mask) & ~align_mask;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_shift    = {div_rem, div_q[BUF_W-1]};
  assign div_ge       = (div_shift >= {1'b0, rbs});
  assign div_rem_next = div_ge ? RBS_W'(div_shift - {1'b0, rbs}) : div_shift[RBS_W-1:0];

  assign div_count = (div_q > MAXB_Q) ? LINK_END : div_q[LINK_W-1:0];
  assign free_ok   = (div_rem == '0) && (div_q < MAXB_Q);
  assign head_prod = list_head * rbs;
  assign fill_next = fill_idx + LINK_W'(1);
  assign res_move  = (state == ST_RESP) && (!out_valid || out_ready);

  always_comb begin
    link_wr_en   = 1'b0;
    link_wr_addr = fill_idx[IDX_W-1:0];
    link_wr_data = (fill_next < fill_cnt) ? fill_next : LINK_END;
    if (state == ST_FILL) begin
      link_wr_en = 1'b1;
    end else if (state == ST_DIV_END && cmd == fbfl_pkg::CMD_FREE && free_ok) begin
      link_wr_en   = 1'b1;
      link_wr_addr = div_q[IDX_W-1:0];
      link_wr_data = list_nonempty ? LINK_W'(list_head) : LINK_END;
    end
  end

  assign link_rd_en = (state == ST_ALLOC_RD);

  fbfl_ram #(
    .WIDTH(LINK_W),
    .DEPTH(MAX_BLOCKS)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (link_wr_en),
    .wr_addr(link_wr_addr),
    .wr_data(link_wr_data),
    .rd_en  (link_rd_en),
    .rd_addr(list_head),
    .rd_data(link_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= '0;
      block_size  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbfl_pkg::REG_BUFFER_SIZE: buffer_size <= cfg_data;
        fbfl_pkg::REG_BLOCK_SIZE:  block_size  <= cfg_data[fbfl_pkg::BLK_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rbs           <= '0;
      list_head     <= '0;
      list_nonempty <= 1'b0;
      free_count    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            res_status <= fbfl_pkg::STATUS_ERR;
            res_offset <= '0;
            res_avail  <= free_count;
            div_rem    <= '0;
            div_cnt    <= '0;
            state      <= ST_RESP;
            case (command)
              fbfl_pkg::CMD_INIT: begin
                if (buffer_size != '0 && block_size != '0) begin
                  rbs   <= rbs_new;
                  div_q <= bytes_capped;
                  state <= ST_DIV;
                end
              end
              fbfl_pkg::CMD_ALLOC: begin
                if (aligned < rbs && list_nonempty) begin
                  state <= ST_ALLOC_RD;
                end
              end
              fbfl_pkg::CMD_FREE: begin
                if (rbs != '0 && BUF_W'(free_offset) < buffer_size) begin
                  div_q <= BUF_W'(free_offset);
                  state <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          div_rem <= div_rem_next;
          div_q   <= {div_q[BUF_W-2:0], div_ge};
          div_cnt <= div_cnt + fbfl_pkg::DIV_CNT_W'(1);
          if (div_cnt == fbfl_pkg::DIV_LAST) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          state <= ST_RESP;
          if (cmd == fbfl_pkg::CMD_INIT) begin
            fill_idx <= '0;
            fill_cnt <= div_count;
            if (div_count == '0) begin
              free_count    <= '0;
              list_head     <= '0;
              list_nonempty <= 1'b0;
              res_status    <= fbfl_pkg::STATUS_OK;
              res_avail     <= '0;
            end else begin
              state <= ST_FILL;
            end
          end else if (free_ok) begin
            list_head     <= div_q[IDX_W-1:0];
            list_nonempty <= 1'b1;
            res_status    <= fbfl_pkg::STATUS_OK;
            if (free_count < LINK_END) begin
              free_count <= free_count + LINK_W'(1);
              res_avail  <= free_count + LINK_W'(1);
            end
          end
        end
        ST_FILL: begin
          fill_idx <= fill_next;
          if (fill_next == fill_cnt) begin
            free_count    <= fill_cnt;
            list_head     <= '0;
            list_nonempty <= 1'b1;
            res_status    <= fbfl_pkg::STATUS_OK;
            res_avail     <= fill_cnt;
            state         <= ST_RESP;
          end
        end
        ST_ALLOC_RD: begin
          res_offset <= OFF_W'(head_prod);
          state      <= ST_ALLOC_UPD;
        end
        ST_ALLOC_UPD: begin
          res_status <= fbfl_pkg::STATUS_OK;
          if (link_rd < LINK_END) begin
            list_head <= link_rd[IDX_W-1:0];
          end else begin
            list_head     <= '0;
            list_nonempty <= 1'b0;
          end
          if (free_count != '0) begin
            free_count <= free_count - LINK_W'(1);
            res_avail  <= free_count - LINK_W'(1);
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (res_move) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      status           <= res_status;
      block_offset     <= res_offset;
      available_blocks <= res_avail;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= LINK_END)
    else $error("free count above block limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new command taken while one is in flight");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt <= fbfl_pkg::DIV_LAST))
    else $error("divider ran past its last step");

  a_link_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_UPD) |-> ($past(state) == ST_ALLOC_RD))
    else $error("link consumed without a read beat before it");

  a_link_write_src: assert property (@(posedge clk) disable iff (rst)
    link_wr_en |-> (state == ST_FILL || (state == ST_DIV_END && cmd == fbfl_pkg::CMD_FREE)))
    else $error("link table written outside init fill or free");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    res_move |=> (state == ST_IDLE && out_valid))
    else $error("result move did not land in output register");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fbfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the free-list link table. No dependencies.
`default_nettype none

module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/fbfl_alloc_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the block allocator: mirrors register writes, predicts
// one response per accepted command and checks each out beat. Uses fbfl_pkg.
module fbfl_alloc_checker #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [fbfl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::BUF_SIZE_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [fbfl_pkg::CMD_W-1:0]            command,
  input  logic [fbfl_pkg::REQ_W-1:0]            request_size,
  input  logic [fbfl_pkg::SHIFT_W-1:0]          align_shift,
  input  logic [fbfl_pkg::OFFSET_WIDTH-1:0]     free_offset,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  status,
  input  logic [fbfl_pkg::OFFSET_WIDTH-1:0]     block_offset,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]       available_blocks,
  output int                                    pending,
  output int                                    mismatches
);
  import fbfl_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int AVAIL_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [AVAIL_W-1:0] LIST_END = AVAIL_W'(MAX_BLOCKS);

  typedef struct packed {
    logic                    status;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [AVAIL_W-1:0]      avail;
  } response_t;

  response_t             awaited_responses[$];
  logic [AVAIL_W-1:0]    link_tbl [MAX_BLOCKS];
  logic [IDX_W-1:0]      head = '0;
  logic                  nonempty = 1'b0;
  logic [AVAIL_W-1:0]    nfree = '0;
  logic [RBS_W-1:0]      blk_rounded = '0;
  logic [BUF_SIZE_W-1:0] buf_bytes = '0;
  logic [BLK_SIZE_W-1:0] blk_bytes = '0;
  int                    bad = 0;
  int                    beats = 0;

  // Updates the free-list mirror and returns the response the command earns.
  function automatic response_t allocator_response(
    input logic [CMD_W-1:0]        cmd,
    input logic [REQ_W-1:0]        req,
    input logic [SHIFT_W-1:0]      shift,
    input logic [OFFSET_WIDTH-1:0] off
  );
    response_t          r;
    longint unsigned    span, cnt, mask, aligned, idx;
    logic [AVAIL_W-1:0] nxt;
    r = '0;
    r.status = STATUS_ERR;
    case (cmd)
      CMD_INIT: begin
        if (buf_bytes != 0 && blk_bytes != 0) begin
          blk_rounded = (RBS_W'(blk_bytes) + RBS_W'(3)) & ~RBS_W'(3);
          span = 64'(buf_bytes);
          // buffer beyond the offset range counts as exactly the range
          if (span > (64'd1 << OFFSET_WIDTH))
            span = 64'd1 << OFFSET_WIDTH;
          cnt = span / 64'(blk_rounded);
          if (cnt > MAX_BLOCKS)
            cnt = MAX_BLOCKS;
          for (longint unsigned i = 0; i < cnt; i++)
            link_tbl[i] = (i + 1 < cnt) ? AVAIL_W'(i + 1) : LIST_END;
          nfree = AVAIL_W'(cnt);
          head = '0;
          nonempty = (cnt != 0);
          r.status = STATUS_OK;
        end
      end
      CMD_ALLOC: begin
        mask = (64'd1 << shift) - 64'd1;
        aligned = (64'(req) + mask) & ~mask;
        if (aligned < 64'(blk_rounded) && nonempty) begin
          r.offset = OFFSET_WIDTH'(64'(head) * 64'(blk_rounded));
          nxt = link_tbl[head];
          if (nxt < LIST_END) begin
            head = IDX_W'(nxt);
          end else begin
            head = '0;
            nonempty = 1'b0;
          end
          if (nfree != 0)
            nfree = nfree - AVAIL_W'(1);
          r.status = STATUS_OK;
        end
      end
      CMD_FREE: begin
        if (blk_rounded != 0 && off < buf_bytes && off % blk_rounded == 0
            && off / blk_rounded < MAX_BLOCKS) begin
          idx = 64'(off / blk_rounded);
          // double frees are pushed again; the count saturates
          link_tbl[idx] = nonempty ? AVAIL_W'(head) : LIST_END;
          head = IDX_W'(idx);
          nonempty = 1'b1;
          if (nfree < LIST_END)
            nfree = nfree + AVAIL_W'(1);
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    r.avail = nfree;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    response_t want;
    response_t got;
    if (rst) begin
      awaited_responses.delete();
      head = '0;
      nonempty = 1'b0;
      nfree = '0;
      blk_rounded = '0;
      buf_bytes = '0;
      blk_bytes = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BUFFER_SIZE)
          buf_bytes = cfg_data;
        else
          blk_bytes = cfg_data[BLK_SIZE_W-1:0];
      end
      if (out_valid && out_ready) begin
        got.status = status;
        got.offset = block_offset;
        got.avail  = available_blocks;
        beats++;
        if (awaited_responses.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: beat %0d with none outstanding: status=%0d offset=%0h avail=%0d",
                     $realtime, beats, got.status, got.offset, got.avail);
        end else begin
          want = awaited_responses.pop_front();
          if (got.status !== want.status || got.offset !== want.offset
              || got.avail !== want.avail) begin
            bad++;
            if (bad <= 10)
              $display("%0t: beat %0d expected st=%0d off=%0h av=%0d, got st=%0d off=%0h av=%0d",
                       $realtime, beats, want.status, want.offset, want.avail,
                       got.status, got.offset, got.avail);
          end
        end
      end
      if (in_valid && in_ready)
        awaited_responses.push_back(
          allocator_response(command, request_size, align_shift, free_offset));
    end
    pending    <= awaited_responses.size();
    mismatches <= bad;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the block allocator testbench: clock, reset, command and register
// stimulus, receiver stalls and the verdict. Uses fbfl_pkg and fbfl_alloc_checker.
module tb;
  import fbfl_pkg::*;

  localparam int MAX_BLOCKS     = 256;
  localparam int AVAIL_W        = $clog2(MAX_BLOCKS + 1);
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int TOTAL_ITEMS    = 2000;
  localparam int QUIET_FIRST    = 900;
  localparam int QUIET_LAST     = 1250;
  localparam int SQUEEZE_AT     = 600;
  localparam int SQUEEZE_CYCLES = 500;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int unsigned OFFSET_SPAN = 1 << OFFSET_WIDTH;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [BUF_SIZE_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        command = '0;
  logic [REQ_W-1:0]        request_size = '0;
  logic [SHIFT_W-1:0]      align_shift = '0;
  logic [OFFSET_WIDTH-1:0] free_offset = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    status;
  logic [OFFSET_WIDTH-1:0] block_offset;
  logic [AVAIL_W-1:0]      available_blocks;

  int          pending;
  int          mismatches;
  int          sent = 0;
  int          cycles = 0;
  int          hold_left = 0;
  bit          squeezed = 1'b0;
  int unsigned geo_rbs = 0;
  int unsigned geo_blocks = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_block_free_list_allocator_top #(.MAX_BLOCKS(MAX_BLOCKS)) dut (.*);

  fbfl_alloc_checker #(.MAX_BLOCKS(MAX_BLOCKS)) chk (.*);

  function automatic bit quiet_stretch();
    return sent >= QUIET_FIRST && sent < QUIET_LAST;
  endfunction

  // Receiver: random stalls, one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (!rst && !squeezed && sent >= SQUEEZE_AT) begin
      squeezed  <= 1'b1;
      hold_left <= SQUEEZE_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet_stretch()) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [BUF_SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes both size registers; only called with nothing in flight.
  task automatic configure(input int unsigned buf_b, input int unsigned blk);
    int unsigned span;
    write_reg(REG_BUFFER_SIZE, BUF_SIZE_W'(buf_b));
    write_reg(REG_BLOCK_SIZE, BUF_SIZE_W'(blk));
    cfg_valid <= 1'b0;
    geo_rbs = (blk == 0) ? 0 : (blk + 3) & ~32'd3;
    span = (buf_b > OFFSET_SPAN) ? OFFSET_SPAN : buf_b;
    geo_blocks = (geo_rbs == 0) ? 0 : span / geo_rbs;
    if (geo_blocks > MAX_BLOCKS)
      geo_blocks = MAX_BLOCKS;
  endtask

  task automatic send(input logic [CMD_W-1:0] c, input logic [REQ_W-1:0] rq,
                      input logic [SHIFT_W-1:0] sh, input logic [OFFSET_WIDTH-1:0] off);
    int gap;
    gap = 0;
    if (!quiet_stretch() && $urandom_range(99) < 20)
      gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= c;
    request_size <= rq;
    align_shift  <= sh;
    free_offset  <= off;
    do @(posedge clk); while (!in_ready);
    sent <= sent + 1;
  endtask

  // Waits until every response is back, so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_session(input int n);
    int unsigned        blk, buf_b, pick, r, p_alloc, k;
    logic [REQ_W-1:0]   rq;
    logic [SHIFT_W-1:0] sh;
    logic [OFFSET_WIDTH-1:0] off;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // a handful of blocks so the list runs empty and refills often
      blk = $urandom_range(1, 64);
      buf_b = $urandom_range(1, 16) * ((blk + 3) & ~32'd3) + $urandom_range(0, 3);
    end else if (pick < 65) begin
      blk = $urandom_range(1, 65535);
      buf_b = $urandom_range(0, 2097151);
    end else if (pick < 73) begin
      blk = $urandom_range(1, 8);
      buf_b = $urandom_range(0, 1) ? OFFSET_SPAN : $urandom_range(OFFSET_SPAN + 1, 2097151);
    end else if (pick < 80) begin
      blk = $urandom_range(65533, 65535);
      buf_b = $urandom_range(983040, OFFSET_SPAN);
    end else if (pick < 86) begin
      // buffer smaller than one block
      blk = $urandom_range(8, 400);
      buf_b = $urandom_range(1, blk - 1);
    end else if (pick < 90) begin
      blk = $urandom_range(0, 1) ? 0 : $urandom_range(1, 100);
      buf_b = (blk == 0) ? $urandom_range(1, 4096) : 0;
    end else begin
      blk = $urandom_range(1, 256);
      buf_b = $urandom_range(17, 256) * ((blk + 3) & ~32'd3);
    end
    configure(buf_b, blk);
    send(CMD_INIT, REQ_W'($urandom), SHIFT_W'($urandom), OFFSET_WIDTH'($urandom));
    p_alloc = $urandom_range(25, 65);
    repeat (n) begin
      rq  = REQ_W'($urandom);
      sh  = SHIFT_W'($urandom);
      off = OFFSET_WIDTH'($urandom);
      r   = $urandom_range(99);
      if (r < p_alloc) begin
        if (geo_rbs != 0 && $urandom_range(9) < 8) begin
          rq = REQ_W'($urandom_range(0, geo_rbs - 1));
          sh = SHIFT_W'($urandom_range(0, 3));
        end
        send(CMD_ALLOC, rq, sh, off);
      end else if (r < 88) begin
        if (geo_blocks != 0 && $urandom_range(9) < 9) begin
          // one index past the table when the count is clamped
          k = $urandom_range(0, geo_blocks - ((geo_blocks == MAX_BLOCKS) ? 0 : 1));
          off = OFFSET_WIDTH'(k * geo_rbs);
        end
        send(CMD_FREE, rq, sh, off);
      end else if (r < 95) begin
        send($urandom_range(0, 1) ? CMD_ALLOC : CMD_FREE, rq, sh, off);
      end else if (r < 98) begin
        send(CMD_NONE, rq, sh, off);
      end else begin
        send(CMD_INIT, rq, sh, off);
      end
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // nothing configured or initialized yet
    send(CMD_ALLOC, '0, '0, '0);
    send(CMD_FREE, '0, '0, '0);
    send(CMD_INIT, '0, '0, '0);
    send(CMD_NONE, '0, '0, '0);
    settle();

    configure(0, 8);
    send(CMD_INIT, '0, '0, '0);
    settle();
    configure(64, 0);
    send(CMD_INIT, '0, '0, '0);
    settle();

    configure(2, 5);
    send(CMD_INIT, '0, '0, '0);
    send(CMD_ALLOC, '0, '0, '0);
    settle();

    // five blocks of eight bytes
    configure(40, 5);
    send(CMD_INIT, '0, '0, '0);
    send(CMD_ALLOC, 16'd7, 4'd0, '0);
    send(CMD_ALLOC, 16'd8, 4'd0, '0);
    send(CMD_ALLOC, 16'd1, 4'd3, '0);
    send(CMD_ALLOC, 16'd1, 4'd2, '0);
    send(CMD_FREE, '0, '0, 20'd0);
    send(CMD_FREE, '0, '0, 20'd12);
    send(CMD_FREE, '0, '0, 20'd40);
    send(CMD_FREE, '0, '0, 20'd0);
    send(CMD_INIT, '0, '0, '0);
    settle();

    // buffer past the offset range, count clamped, free saturates
    configure(2097151, 1);
    send(CMD_INIT, '0, '0, '0);
    send(CMD_FREE, '0, '0, 20'd0);
    send(CMD_FREE, '0, '0, 20'd1024);
    send(CMD_ALLOC, 16'hFFFF, 4'hF, '0);
    send(CMD_ALLOC, 16'd3, 4'd0, '0);
    settle();

    configure(OFFSET_SPAN, 65535);
    send(CMD_INIT, '0, '0, '0);
    send(CMD_ALLOC, 16'hFFFF, 4'd0, '0);
    send(CMD_FREE, '0, '0, 20'd983040);
    send(CMD_NONE, '1, '1, '1);
    settle();

    while (sent < TOTAL_ITEMS)
      random_session($urandom_range(40, 200));

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_ram.sv
rtl/core/fixed_block_free_list_allocator_top.sv
tb/fbfl_alloc_checker.sv
tb/tb.sv
